/* src/ecd_pkg.sv */
// ============================================================================
// ecd_pkg: shared definitions for the epoch-seconds to date-text core
// Widths, constants and the command/status bundles between the controller
// and the datapath.
// ============================================================================
package ecd_pkg;

    localparam int TIME_BITS_DEFAULT = 38;

    // saturation limit: 9999-12-31 23:59:59
    localparam int                   SAT_BITS    = 38;
    localparam logic [SAT_BITS-1:0]  LAST_SECOND = 38'd253402300799;

    // division by seconds per day: 86400 = 2^7 * 675; the remaining 31 bits
    // divided by 675 equal floor(x * ceil(2^41 / 675) / 2^41), exact for all x
    localparam int                           SECS_PER_DAY_BITS = 17;
    localparam logic [SECS_PER_DAY_BITS-1:0] SECS_PER_DAY      = 17'd86400;
    localparam int                           DAY_SHIFT         = 7;
    localparam int                           DIV_IN_BITS       = SAT_BITS - DAY_SHIFT;
    localparam int                           RECIP_BITS        = 32;
    localparam logic [RECIP_BITS-1:0]        RECIP_675         = 32'd3257812231;
    localparam int                           RECIP_SHIFT       = 41;
    localparam int                           PROD_BITS         = DIV_IN_BITS + RECIP_BITS;

    // day count since epoch fits in 22 bits (max 2932896)
    localparam int DAY_BITS   = 22;
    localparam int YEAR_BITS  = 14;
    localparam int MONTH_BITS = 4;
    localparam int DOM_BITS   = 5;
    localparam int CHAR_BITS  = 7;

    localparam logic [YEAR_BITS-1:0] EPOCH_YEAR = 14'd1970;

    // result tdata: char_code, day, month, year, zero fill
    localparam int OUT_DATA_BITS = 32;

    localparam int TEXT_LEN      = 11;
    localparam int CHAR_IDX_BITS = $clog2(TEXT_LEN);

    typedef struct packed {
        logic load;
        logic div_step;
        logic year_step;
        logic month_step;
        logic emit_step;
    } ecd_cmd_t;

    typedef struct packed {
        logic div_done;
        logic year_found;
        logic month_found;
        logic last_char;
    } ecd_status_t;

endpackage

/* src/ecd_ctrl.sv */
// ============================================================================
// ecd_ctrl: sequencer for the date conversion
// Steps through divide, year walk, month walk and text emission.
// ============================================================================
module ecd_ctrl
    import ecd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  ecd_status_t status,
    output ecd_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_YEARS,
        ST_MONTHS,
        ST_EMIT
    } state_t;

    state_t state_reg;
    logic   s_tready_reg;
    logic   m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            s_tready_reg <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid && s_tready_reg) begin
                        state_reg    <= ST_DIVIDE;
                        s_tready_reg <= 1'b0;
                    end
                end
                ST_DIVIDE: begin
                    if (status.div_done) begin
                        state_reg <= ST_YEARS;
                    end
                end
                ST_YEARS: begin
                    if (status.year_found) begin
                        state_reg <= ST_MONTHS;
                    end
                end
                ST_MONTHS: begin
                    if (status.month_found) begin
                        state_reg    <= ST_EMIT;
                        m_tvalid_reg <= 1'b1;
                    end
                end
                ST_EMIT: begin
                    if (m_tready && status.last_char) begin
                        state_reg    <= ST_IDLE;
                        m_tvalid_reg <= 1'b0;
                        s_tready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        cmd            = '0;
        cmd.load       = (state_reg == ST_IDLE) && s_tvalid && s_tready_reg;
        cmd.div_step   = (state_reg == ST_DIVIDE);
        cmd.year_step  = (state_reg == ST_YEARS) && !status.year_found;
        cmd.month_step = (state_reg == ST_MONTHS) && !status.month_found;
        cmd.emit_step  = (state_reg == ST_EMIT) && m_tvalid_reg && m_tready;
    end

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule

/* src/ecd_datapath.sv */
// ============================================================================
// ecd_datapath: arithmetic for the date conversion
// Saturation, reciprocal divide by 86400, year and month walks, text bytes.
// ============================================================================
module ecd_datapath
    import ecd_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
    input  logic                  aclk,
    input  logic [TIME_BITS-1:0]  ts_in,
    input  ecd_cmd_t              cmd,
    output ecd_status_t           status,
    output logic [CHAR_BITS-1:0]  char_code,
    output logic [DOM_BITS-1:0]   day_of_month,
    output logic [MONTH_BITS-1:0] month_number,
    output logic [YEAR_BITS-1:0]  year_number
);

    localparam int CMP_BITS = (TIME_BITS > SAT_BITS) ? TIME_BITS : SAT_BITS;

    localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 7'd48;
    localparam logic [CHAR_BITS-1:0] ASCII_DOT  = 7'd46;
    localparam logic [CHAR_BITS-1:0] ASCII_NL   = 7'd10;

    // text positions
    localparam logic [CHAR_IDX_BITS-1:0] POS_DAY_TENS   = 4'd0;
    localparam logic [CHAR_IDX_BITS-1:0] POS_DAY_ONES   = 4'd1;
    localparam logic [CHAR_IDX_BITS-1:0] POS_DOT_A      = 4'd2;
    localparam logic [CHAR_IDX_BITS-1:0] POS_MON_TENS   = 4'd3;
    localparam logic [CHAR_IDX_BITS-1:0] POS_MON_ONES   = 4'd4;
    localparam logic [CHAR_IDX_BITS-1:0] POS_DOT_B      = 4'd5;
    localparam logic [CHAR_IDX_BITS-1:0] POS_YEAR_THOU  = 4'd6;
    localparam logic [CHAR_IDX_BITS-1:0] POS_YEAR_HUND  = 4'd7;
    localparam logic [CHAR_IDX_BITS-1:0] POS_YEAR_TENS  = 4'd8;
    localparam logic [CHAR_IDX_BITS-1:0] POS_YEAR_ONES  = 4'd9;
    localparam logic [CHAR_IDX_BITS-1:0] POS_NEWLINE    = 4'd10;

    function automatic logic [4:0] month_len(input logic [3:0] idx, input logic leap);
        logic [4:0] len;
        unique case (idx)
            4'd1:                      len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [1:0] tens_of(input logic [4:0] v);
        logic [1:0] t;
        if (v >= 5'd30) begin
            t = 2'd3;
        end else if (v >= 5'd20) begin
            t = 2'd2;
        end else if (v >= 5'd10) begin
            t = 2'd1;
        end else begin
            t = 2'd0;
        end
        return t;
    endfunction

    // ---- saturation ----
    logic [CMP_BITS-1:0] ts_wide;
    logic [SAT_BITS-1:0] ts_sat;

    assign ts_wide = CMP_BITS'(ts_in);
    assign ts_sat  = (ts_wide > CMP_BITS'(LAST_SECOND)) ? LAST_SECOND
                                                        : ts_wide[SAT_BITS-1:0];

    // ---- divide ----
    // drop the factor 128, then multiply by the reciprocal of 675:
    // first step registers the product, second step takes the day count
    logic [DIV_IN_BITS-1:0] dividend_reg;
    logic [PROD_BITS-1:0]   prod_reg;
    logic                   div_phase_reg;

    // ---- calendar state ----
    logic [DAY_BITS-1:0]   days_reg;
    logic [YEAR_BITS-1:0]  year_reg;
    logic [3:0]            ydig_reg [4];   // BCD, index 0 = ones
    logic [1:0]            mod4_reg;
    logic [6:0]            mod100_reg;
    logic [8:0]            mod400_reg;
    logic [MONTH_BITS-1:0] mon_idx_reg;
    logic [CHAR_IDX_BITS-1:0] char_idx_reg;

    logic       leap;
    logic [8:0] ylen;
    logic [4:0] mlen;
    logic [3:0] ydig_inc [4];
    logic       carry [5];

    assign leap = ((mod4_reg == 2'd0) && (mod100_reg != 7'd0)) || (mod400_reg == 9'd0);
    assign ylen = leap ? 9'd366 : 9'd365;
    assign mlen = month_len(mon_idx_reg, leap);

    always_comb begin
        carry[0] = 1'b1;
        for (int i = 0; i < 4; i++) begin
            if (carry[i]) begin
                ydig_inc[i] = (ydig_reg[i] == 4'd9) ? 4'd0 : ydig_reg[i] + 4'd1;
                carry[i+1]  = (ydig_reg[i] == 4'd9);
            end else begin
                ydig_inc[i] = ydig_reg[i];
                carry[i+1]  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            dividend_reg  <= ts_sat[SAT_BITS-1:DAY_SHIFT];
            div_phase_reg <= 1'b0;
            days_reg      <= '0;
            year_reg      <= EPOCH_YEAR;
            ydig_reg[3]   <= 4'd1;
            ydig_reg[2]   <= 4'd9;
            ydig_reg[1]   <= 4'd7;
            ydig_reg[0]   <= 4'd0;
            mod4_reg      <= 2'd2;
            mod100_reg    <= 7'd70;
            mod400_reg    <= 9'd370;
            mon_idx_reg   <= '0;
            char_idx_reg  <= '0;
        end
        if (cmd.div_step) begin
            if (!div_phase_reg) begin
                prod_reg      <= PROD_BITS'(dividend_reg) * PROD_BITS'(RECIP_675);
                div_phase_reg <= 1'b1;
            end else begin
                days_reg      <= prod_reg[RECIP_SHIFT +: DAY_BITS];
            end
        end
        if (cmd.year_step) begin
            days_reg   <= days_reg - DAY_BITS'(ylen);
            year_reg   <= year_reg + YEAR_BITS'(1);
            for (int i = 0; i < 4; i++) begin
                ydig_reg[i] <= ydig_inc[i];
            end
            mod4_reg   <= mod4_reg + 2'd1;
            mod100_reg <= (mod100_reg == 7'd99) ? 7'd0 : mod100_reg + 7'd1;
            mod400_reg <= (mod400_reg == 9'd399) ? 9'd0 : mod400_reg + 9'd1;
        end
        if (cmd.month_step) begin
            days_reg    <= days_reg - DAY_BITS'(mlen);
            mon_idx_reg <= mon_idx_reg + MONTH_BITS'(1);
        end
        if (cmd.emit_step) begin
            char_idx_reg <= char_idx_reg + CHAR_IDX_BITS'(1);
        end
    end

    // ---- status ----
    always_comb begin
        status             = '0;
        status.div_done    = div_phase_reg;
        status.year_found  = (days_reg < DAY_BITS'(ylen));
        status.month_found = (days_reg < DAY_BITS'(mlen));
        status.last_char   = (char_idx_reg == POS_NEWLINE);
    end

    // ---- result fields ----
    logic [1:0] day_tens;
    logic [4:0] day_ones;
    logic [1:0] mon_tens;
    logic [4:0] mon_ones;

    assign day_of_month = days_reg[DOM_BITS-1:0] + DOM_BITS'(1);
    assign month_number = mon_idx_reg + MONTH_BITS'(1);
    assign year_number  = year_reg;

    assign day_tens = tens_of(day_of_month);
    assign day_ones = day_of_month - 5'(day_tens) * 5'd10;
    assign mon_tens = tens_of({1'b0, month_number});
    assign mon_ones = {1'b0, month_number} - 5'(mon_tens) * 5'd10;

    always_comb begin
        unique case (char_idx_reg)
            POS_DAY_TENS:  char_code = ASCII_ZERO + 7'(day_tens);
            POS_DAY_ONES:  char_code = ASCII_ZERO + 7'(day_ones);
            POS_DOT_A:     char_code = ASCII_DOT;
            POS_MON_TENS:  char_code = ASCII_ZERO + 7'(mon_tens);
            POS_MON_ONES:  char_code = ASCII_ZERO + 7'(mon_ones);
            POS_DOT_B:     char_code = ASCII_DOT;
            POS_YEAR_THOU: char_code = ASCII_ZERO + 7'(ydig_reg[3]);
            POS_YEAR_HUND: char_code = ASCII_ZERO + 7'(ydig_reg[2]);
            POS_YEAR_TENS: char_code = ASCII_ZERO + 7'(ydig_reg[1]);
            POS_YEAR_ONES: char_code = ASCII_ZERO + 7'(ydig_reg[0]);
            default:       char_code = ASCII_NL;
        endcase
    end

endmodule

/* src/epoch_seconds_to_date_text_core.sv */
// Sequence: the divide registers the product, then takes the day count; then
// the year walk (one year per cycle), the month walk and 11 text bytes.
// Flow: a new item is accepted only after the last text byte of the previous
// one has been taken.
// Reset: aresetn synchronous, active low; clears the sequencer only. The core
// then accepts an item and emits no bytes until one has been processed.
// ============================================================================
// epoch_seconds_to_date_text_core: Unix seconds to DD.MM.YYYY text
// Saturates at end of year 9999, walks years and months, emits 11 ASCII
// bytes with the newline flagged by m_tlast.
// ============================================================================
module epoch_seconds_to_date_text_core
    import ecd_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // input item
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // [TIME_BITS-1:0] timestamp_seconds, rest zero
    input  logic [((TIME_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // result items
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [6:0] char_code, [11:7] day_of_month, [15:12] month_number,
    // [29:16] year_number, [31:30] zero
    output logic [OUT_DATA_BITS-1:0]              m_tdata,
    output logic                                  m_tlast   // is_last
);

    ecd_cmd_t              cmd;
    ecd_status_t           status;
    logic [CHAR_BITS-1:0]  char_code;
    logic [DOM_BITS-1:0]   day_of_month;
    logic [MONTH_BITS-1:0] month_number;
    logic [YEAR_BITS-1:0]  year_number;

    // sequencer: owns both handshakes
    ecd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: divide, calendar walk, byte select
    ecd_datapath #(
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .ts_in        (s_tdata[TIME_BITS-1:0]),
        .cmd          (cmd),
        .status       (status),
        .char_code    (char_code),
        .day_of_month (day_of_month),
        .month_number (month_number),
        .year_number  (year_number)
    );

    // all result fields come from registers held through the emit phase
    assign m_tdata = {2'b00, year_number, month_number, day_of_month, char_code};
    assign m_tlast = status.last_char;

`ifndef NO_ASSERTIONS
    // input side and output side are never open together
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("input accepted while result pending");

    // an accepted item closes the input until its text is delivered
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input reopened after accept");

    // the newline byte ends the item and reopens the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("core did not return to idle after last byte");

    // emitted date is a sane calendar value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (month_number >= 4'd1 && month_number <= 4'd12 &&
                      day_of_month != 5'd0 && year_number >= EPOCH_YEAR))
        else $error("date field out of range");
`endif

endmodule
